// ===== src/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared codes, widths and types of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // fixed field widths
  localparam int FRAME_W    = 18;
  localparam int CNT_W      = 19;
  localparam int OWN_PORT_W = 16;
  localparam int TOTAL_W    = 32;
  localparam int WORD_W     = 64;
  localparam int OFS_W      = 6;
  // internal frame positions (frame + count never reaches 2^20)
  localparam int POS_W      = 21;

  localparam logic [CNT_W-1:0] MANAGED_RESET = 19'd262144;

  // operation codes
  localparam logic [2:0] OP_ALLOC_FRAME = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN   = 3'd1;
  localparam logic [2:0] OP_FREE_FRAME  = 3'd2;
  localparam logic [2:0] OP_FREE_RUN    = 3'd3;
  localparam logic [2:0] OP_ADD_OWNER   = 3'd4;
  localparam logic [2:0] OP_READ_OWNERS = 3'd5;
  localparam logic [2:0] OP_RESERVE     = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_RESERVED  = 3'd4;
  localparam logic [2:0] ST_CNT_WRAP  = 3'd5;
  localparam logic [2:0] ST_SHARED    = 3'd6;

  // result of scanning one bitmap word
  typedef struct packed {
    logic             found;  // a blocking bit lies at or after the offset
    logic [OFS_W-1:0] idx;    // position of that bit
    logic [OFS_W:0]   len;    // free frames from the offset up to it
  } scan_res_t;

endpackage

// ===== src/pfa_word_scan.sv =====
// ----------------------------------------------------------------------------
// pfa_word_scan
// Finds the first used or cut-off frame of a bitmap word at or after an offset.
// ----------------------------------------------------------------------------
module pfa_word_scan
  import pfa_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [OFS_W-1:0]  offset,
  input  logic              cut,
  input  logic [OFS_W-1:0]  cut_idx,
  output scan_res_t         res
);

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] blocked;

  // frames past the search end count as used
  always_comb begin
    lo_mask = (WORD_W'(1) << offset) - WORD_W'(1);
    hi_mask = cut ? ~((WORD_W'(1) << cut_idx) - WORD_W'(1)) : '0;
    blocked = (word | hi_mask) & ~lo_mask;
  end

  // priority encoder, lowest blocking bit wins
  always_comb begin
    res.found = |blocked;
    res.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (blocked[i]) begin
        res.idx = OFS_W'(i);
      end
    end
    res.len = (res.found ? {1'b0, res.idx} : (OFS_W + 1)'(WORD_W)) - {1'b0, offset};
  end

endmodule

// ===== src/page_frame_allocator_refcount_unit.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_unit
// Bitmap next-fit page frame allocator with per-frame owner counts.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   req_valid req_stall op frame count        in (stall out)
//  response  rsp_valid rsp_stall status alloc_frame    out (stall in)
//            owners free_frames shared_frames
//            extra_owner_total last_release_total
//  config    cfg_we cfg_wdata (managed_pages)          in
//
//  After reset the bitmap memory is cleared one word a cycle; requests stall
//  during that pass. Single-frame free, add owner and read owners fetch the
//  frame, then update it. Allocation fetches and scans the bitmap a word at
//  a time and steps over used frames one by one, then writes one frame a
//  cycle and loads and writes back each word touched. Free run checks each
//  frame in turn, then clears as above; reserve writes as above.
//  One request is in work at a time; a held response stalls only its finish.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_unit
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 262144,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [2:0]            op,
  input  logic [FRAME_W-1:0]    frame,
  input  logic [CNT_W-1:0]      count,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [2:0]            status,
  output logic [FRAME_W-1:0]    alloc_frame,
  output logic [OWN_PORT_W-1:0] owners,
  output logic [CNT_W-1:0]      free_frames,
  output logic [CNT_W-1:0]      shared_frames,
  output logic [TOTAL_W-1:0]    extra_owner_total,
  output logic [TOTAL_W-1:0]    last_release_total
);

  localparam int FW        = $clog2(NUM_FRAMES);
  localparam int MAP_WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OP, S_SRD, S_SCAN, S_FRR, S_FRC, S_SW, S_SWL, S_DONE
  } state_t;

  typedef enum logic [1:0] {SW_ALLOC, SW_RESERVE, SW_FREE} sw_kind_t;

  function automatic logic [OWN_PORT_W-1:0] to_port(logic [OWNER_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OWN_PORT_W-1:0];
  endfunction

  // memories
  logic [WORD_W-1:0]     map_mem [MAP_WORDS];
  logic [OWNER_BITS-1:0] own_mem [NUM_FRAMES];
  logic                  map_re, map_we, own_re, own_we;
  logic [WA-1:0]         map_ra, map_wa;
  logic [WORD_W-1:0]     map_wd, map_q;
  logic [FW-1:0]         own_ra, own_wa;
  logic [OWNER_BITS-1:0] own_wd, own_q;

  // registers
  state_t                state, state_next;
  sw_kind_t              kind, kind_next;
  logic [WA-1:0]         clr_addr, clr_addr_next;
  logic [CNT_W-1:0]      managed_pages, managed_pages_next;
  logic [CNT_W-1:0]      hint, hint_next;
  logic [CNT_W-1:0]      used_total, used_total_next;
  logic [CNT_W-1:0]      shared_total, shared_total_next;
  logic [TOTAL_W-1:0]    extra_cnt, extra_cnt_next;
  logic [TOTAL_W-1:0]    release_cnt, release_cnt_next;
  logic [2:0]            r_op, r_op_next;
  logic [POS_W-1:0]      r_frame, r_frame_next;
  logic [POS_W-1:0]      r_count, r_count_next;
  logic [POS_W-1:0]      r_n, r_n_next;
  logic [POS_W-1:0]      p, p_next;
  logic [POS_W-1:0]      run, run_next;
  logic [POS_W-1:0]      s_end, s_end_next;
  logic                  pass, pass_next;
  logic [WORD_W-1:0]     wd, wd_next;
  logic                  wv, wv_next;
  logic [2:0]            res_status, res_status_next;
  logic [POS_W-1:0]      res_frame, res_frame_next;
  logic [OWNER_BITS-1:0] res_owners, res_owners_next;
  logic                  rsp_valid_next;
  logic                  rsp_load;

  // derived values
  logic [CNT_W-1:0] m;
  logic [POS_W-1:0] m_pos, h_pos, fpos;
  logic             accept;
  scan_res_t        sr;

  assign m = ({2'b0, managed_pages} < POS_W'(NUM_FRAMES)) ? managed_pages
                                                          : CNT_W'(NUM_FRAMES);
  assign m_pos     = POS_W'(m);
  assign h_pos     = POS_W'(hint);
  assign fpos      = POS_W'(frame);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // bitmap word scanner
  pfa_word_scan u_scan (
    .word    (map_q),
    .offset  (p[OFS_W-1:0]),
    .cut     (s_end[POS_W-1:OFS_W] == p[POS_W-1:OFS_W]),
    .cut_idx (s_end[OFS_W-1:0]),
    .res     (sr)
  );

  // bitmap memory
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_q <= map_mem[map_ra];
    end
  end

  // owner count memory
  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    if (own_re) begin
      own_q <= own_mem[own_ra];
    end
  end

  // sequencer
  always_comb begin
    logic                  bit_used;
    logic [OWNER_BITS-1:0] ow0;
    logic [OWNER_BITS-1:0] nw;
    logic [POS_W-1:0]      base, total, u, pn, s, e2, lim_end;
    logic                  exhausted, in_range;
    logic [WORD_W-1:0]     wd_new;

    state_next         = state;
    kind_next          = kind;
    clr_addr_next      = clr_addr;
    managed_pages_next = cfg_we ? cfg_wdata : managed_pages;
    hint_next          = hint;
    used_total_next    = used_total;
    shared_total_next  = shared_total;
    extra_cnt_next     = extra_cnt;
    release_cnt_next   = release_cnt;
    r_op_next          = r_op;
    r_frame_next       = r_frame;
    r_count_next       = r_count;
    r_n_next           = r_n;
    p_next             = p;
    run_next           = run;
    s_end_next         = s_end;
    pass_next          = pass;
    wd_next            = wd;
    wv_next            = wv;
    res_status_next    = res_status;
    res_frame_next     = res_frame;
    res_owners_next    = res_owners;
    rsp_valid_next     = rsp_valid && rsp_stall;
    rsp_load           = 1'b0;

    map_re = 1'b0;
    map_ra = p[WA+OFS_W-1:OFS_W];
    map_we = 1'b0;
    map_wa = p[WA+OFS_W-1:OFS_W];
    map_wd = '0;
    own_re = 1'b0;
    own_ra = p[FW-1:0];
    own_we = 1'b0;
    own_wa = p[FW-1:0];
    own_wd = '0;

    bit_used  = map_q[p[OFS_W-1:0]];
    ow0       = '0;
    nw        = '0;
    base      = {p[POS_W-1:OFS_W], {OFS_W{1'b0}}};
    total     = run + POS_W'(sr.len);
    u         = base + POS_W'(sr.idx);
    pn        = p + POS_W'(1);
    s         = p - run;
    e2        = (h_pos < m_pos) ? h_pos : m_pos;
    lim_end   = r_frame + r_count;
    exhausted = 1'b0;
    in_range  = r_frame < m_pos;
    wd_new    = wd;

    case (state)
      // bitmap clearing pass after reset
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_addr;
        map_wd = '0;
        clr_addr_next = clr_addr + WA'(1);
        if (clr_addr == WA'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      // take a request, fetch the named frame
      S_IDLE: begin
        if (accept) begin
          r_op_next       = op;
          r_frame_next    = fpos;
          r_count_next    = POS_W'(count);
          res_frame_next  = '0;
          res_owners_next = '0;
          res_status_next = ST_OK;
          map_re = 1'b1;
          map_ra = fpos[WA+OFS_W-1:OFS_W];
          own_re = 1'b1;
          own_ra = fpos[FW-1:0];
          if (op == OP_ALLOC_FRAME || op == OP_ALLOC_RUN) begin
            r_n_next = (op == OP_ALLOC_FRAME) ? POS_W'(1) : POS_W'(count);
            run_next = '0;
            if (op == OP_ALLOC_RUN && count == '0) begin
              res_status_next = ST_NO_SPACE;
              state_next      = S_DONE;
            end else if (h_pos < m_pos) begin
              pass_next  = 1'b0;
              p_next     = h_pos;
              s_end_next = m_pos;
              state_next = S_SRD;
            end else begin
              pass_next  = 1'b1;
              p_next     = '0;
              s_end_next = m_pos;
              if (m == '0) begin
                res_status_next = ST_NO_SPACE;
                state_next      = S_DONE;
              end else begin
                state_next = S_SRD;
              end
            end
          end else begin
            state_next = S_OP;
          end
        end
      end

      // single-frame operations and setup of the range ones
      S_OP: begin
        bit_used = map_q[r_frame[OFS_W-1:0]];
        ow0      = bit_used ? own_q : '0;
        nw       = own_q - OWNER_BITS'(1);
        res_owners_next = in_range ? ow0 : '0;
        state_next      = S_DONE;
        own_wa = r_frame[FW-1:0];
        map_wa = r_frame[WA+OFS_W-1:OFS_W];
        case (r_op)
          OP_FREE_FRAME: begin
            if (!in_range) begin
              res_status_next = ST_BAD_RANGE;
            end else if (!bit_used) begin
              res_status_next = ST_NOT_ALLOC;
            end else if (own_q == '0) begin
              res_status_next = ST_RESERVED;
            end else begin
              own_we = 1'b1;
              own_wd = nw;
              res_owners_next = nw;
              if (own_q == OWNER_BITS'(2)) begin
                shared_total_next = shared_total - CNT_W'(1);
              end
              if (nw == '0) begin
                release_cnt_next = release_cnt + TOTAL_W'(1);
                used_total_next  = used_total - CNT_W'(1);
                map_we = 1'b1;
                map_wd = map_q & ~(WORD_W'(1) << r_frame[OFS_W-1:0]);
                if (r_frame < h_pos) begin
                  hint_next = CNT_W'(r_frame);
                end
              end
            end
          end
          OP_FREE_RUN: begin
            if (r_count != '0) begin
              p_next     = r_frame;
              s_end_next = lim_end;
              state_next = S_FRR;
            end
          end
          OP_ADD_OWNER: begin
            if (!in_range) begin
              res_status_next = ST_BAD_RANGE;
            end else if (!bit_used || own_q == '0) begin
              res_status_next = ST_NOT_ALLOC;
            end else if (own_q == '1) begin
              res_status_next = ST_CNT_WRAP;
            end else begin
              own_we = 1'b1;
              own_wd = own_q + OWNER_BITS'(1);
              res_owners_next = own_q + OWNER_BITS'(1);
              extra_cnt_next  = extra_cnt + TOTAL_W'(1);
              if (own_q == OWNER_BITS'(1)) begin
                shared_total_next = shared_total + CNT_W'(1);
              end
            end
          end
          OP_READ_OWNERS: begin
            if (!in_range) begin
              res_status_next = ST_BAD_RANGE;
            end
          end
          OP_RESERVE: begin
            if (in_range && r_count != '0) begin
              p_next     = r_frame;
              s_end_next = (lim_end > m_pos) ? m_pos : lim_end;
              kind_next  = SW_RESERVE;
              wv_next    = 1'b0;
              state_next = S_SW;
            end
          end
          default: begin
            res_owners_next = '0;
          end
        endcase
      end

      // search: fetch the word under the cursor
      S_SRD: begin
        map_re     = 1'b1;
        state_next = S_SCAN;
      end

      // search: step over one free stretch or one used frame
      S_SCAN: begin
        if (total >= r_n) begin
          used_total_next = used_total + r_n[CNT_W-1:0];
          if (r_n == POS_W'(1)) begin
            hint_next = (s + POS_W'(1) >= m_pos) ? '0 : CNT_W'(s + POS_W'(1));
          end else begin
            hint_next = CNT_W'(s + r_n);
          end
          res_frame_next  = s;
          res_owners_next = OWNER_BITS'(1);
          p_next     = s;
          s_end_next = s + r_n;
          kind_next  = SW_ALLOC;
          wv_next    = 1'b0;
          state_next = S_SW;
        end else if (sr.found) begin
          run_next = '0;
          p_next   = u + POS_W'(1);
          if (u >= s_end || u + POS_W'(1) >= s_end) begin
            exhausted = 1'b1;
          end else if (sr.idx == '1) begin
            state_next = S_SRD;
          end
        end else begin
          run_next = total;
          p_next   = base + POS_W'(WORD_W);
          if (base + POS_W'(WORD_W) >= s_end) begin
            exhausted = 1'b1;
          end else begin
            state_next = S_SRD;
          end
        end
        if (exhausted) begin
          run_next = '0;
          if (!pass && e2 != '0) begin
            pass_next  = 1'b1;
            p_next     = '0;
            s_end_next = e2;
            state_next = S_SRD;
          end else begin
            res_status_next = ST_NO_SPACE;
            res_owners_next = '0;
            state_next      = S_DONE;
          end
        end
      end

      // free run check: fetch one frame
      S_FRR: begin
        if (p >= m_pos) begin
          res_status_next = ST_BAD_RANGE;
          state_next      = S_DONE;
        end else begin
          map_re     = 1'b1;
          own_re     = 1'b1;
          state_next = S_FRC;
        end
      end

      // free run check: test one frame
      S_FRC: begin
        if (!bit_used) begin
          res_status_next = ST_NOT_ALLOC;
          state_next      = S_DONE;
        end else if (own_q == '0) begin
          res_status_next = ST_RESERVED;
          state_next      = S_DONE;
        end else if (own_q != OWNER_BITS'(1)) begin
          res_status_next = ST_SHARED;
          state_next      = S_DONE;
        end else if (pn == s_end) begin
          used_total_next  = used_total - r_count[CNT_W-1:0];
          release_cnt_next = release_cnt + TOTAL_W'(r_count);
          if (r_frame < h_pos) begin
            hint_next = CNT_W'(r_frame);
          end
          res_owners_next = '0;
          p_next     = r_frame;
          kind_next  = SW_FREE;
          wv_next    = 1'b0;
          state_next = S_SW;
        end else begin
          p_next     = pn;
          state_next = S_FRR;
        end
      end

      // range update, one frame a cycle with the word held in wd
      S_SW: begin
        if (!wv) begin
          map_re     = 1'b1;
          state_next = S_SWL;
        end else begin
          case (kind)
            SW_ALLOC: begin
              wd_new[p[OFS_W-1:0]] = 1'b1;
              own_we = 1'b1;
              own_wd = OWNER_BITS'(1);
            end
            SW_RESERVE: begin
              if (!wd[p[OFS_W-1:0]]) begin
                wd_new[p[OFS_W-1:0]] = 1'b1;
                own_we = 1'b1;
                own_wd = '0;
                used_total_next = used_total + CNT_W'(1);
              end
            end
            default: begin
              wd_new[p[OFS_W-1:0]] = 1'b0;
            end
          endcase
          wd_next = wd_new;
          p_next  = pn;
          if (pn == s_end || pn[OFS_W-1:0] == '0) begin
            map_we  = 1'b1;
            map_wd  = wd_new;
            wv_next = 1'b0;
          end
          if (pn == s_end) begin
            state_next = S_DONE;
          end
        end
      end

      S_SWL: begin
        wd_next    = map_q;
        wv_next    = 1'b1;
        state_next = S_SW;
      end

      // hand the result to the response register
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      managed_pages <= MANAGED_RESET;
      hint          <= '0;
      used_total    <= '0;
      shared_total  <= '0;
      extra_cnt     <= '0;
      release_cnt   <= '0;
      wv            <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      managed_pages <= managed_pages_next;
      hint          <= hint_next;
      used_total    <= used_total_next;
      shared_total  <= shared_total_next;
      extra_cnt     <= extra_cnt_next;
      release_cnt   <= release_cnt_next;
      wv            <= wv_next;
      rsp_valid     <= rsp_valid_next;
    end
    kind       <= kind_next;
    r_op       <= r_op_next;
    r_frame    <= r_frame_next;
    r_count    <= r_count_next;
    r_n        <= r_n_next;
    p          <= p_next;
    run        <= run_next;
    s_end      <= s_end_next;
    pass       <= pass_next;
    wd         <= wd_next;
    res_status <= res_status_next;
    res_frame  <= res_frame_next;
    res_owners <= res_owners_next;
    if (rsp_load) begin
      status             <= res_status;
      alloc_frame        <= res_frame[FRAME_W-1:0];
      owners             <= to_port(res_owners);
      free_frames        <= (m > used_total) ? (m - used_total) : '0;
      shared_frames      <= shared_total;
      extra_owner_total  <= extra_cnt;
      last_release_total <= release_cnt;
    end
  end

endmodule
